[hw/rtl/rau_pkg.sv]
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;
  localparam int OPERAND_WIDTH = 16;
  localparam int OUT_WIDTH = 34;
  localparam int PROD_W = 2 * OPERAND_WIDTH;
  localparam int MAG_W = PROD_W + 1;
  localparam int CNT_W = $clog2(MAG_W + 1);

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_SUM, ST_GCD_START, ST_GCD_DIV,
    ST_RED_NUM, ST_RED_DEN, ST_DIV_WAIT, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [MAG_W-1:0] dividend;
    logic [MAG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic busy;
    logic [MAG_W-1:0] quot;
    logic [MAG_W-1:0] rem;
  } div_rsp_t;
endpackage

[hw/rtl/rau_divider.sv]
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module rau_divider (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t rsp
);
  import rau_pkg::*;

  logic [MAG_W-1:0] quot, rem, dsor;
  logic [CNT_W-1:0] cnt;
  logic             busy, done;
  logic [MAG_W:0]   trial;
  logic [MAG_W:0]   shifted;

  assign shifted = {rem, quot[MAG_W-1]};
  assign trial = shifted - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quot <= req.dividend;
        rem <= '0;
        dsor <= req.divisor;
        cnt <= CNT_W'(MAG_W);
      end else if (busy) begin
        if (!trial[MAG_W]) begin
          rem <= trial[MAG_W-1:0];
          quot <= {quot[MAG_W-2:0], 1'b1};
        end else begin
          rem <= shifted[MAG_W-1:0];
          quot <= {quot[MAG_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.quot = quot;
  assign rsp.rem = rem;
endmodule

[hw/rtl/rational_arith_unit.sv]
// Top level of the rational arithmetic unit.
//
// Usage: a request carries func and two fractions a_num/a_den, b_num/b_den
// on a valid/ready input channel. The block forms the raw fraction (cross
// products for add/sub unless denominators match, direct products for
// multiply, a times the inverse of b for divide), reduces it by the
// Euclidean gcd with truncated remainders, and presents res_num, res_den
// and zero_den_error on a valid/ready output channel.
// Sequence: the multiply/sum setup states MUL1, MUL2, MUL3 and SUM, then per
// Euclid remainder step the shared serial divider plus start and update
// states, a final GCD_START to close the loop, and the two exact divisions
// by the gcd. 33-bit magnitudes need at most about 47 steps. Zero over zero
// skips the divisions.
// One request is in flight at a time; in_ready returns the cycle after the
// result is taken.
// Reset clears the sequencer and output valid; no clearing pass needed.
// When the receiver stalls, the result is held in the output register and
// in_ready stays low until it is taken.
module rational_arith_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          func,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_num,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_den,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_num,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_den,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rau_pkg::OUT_WIDTH-1:0] res_num,
  output logic signed [rau_pkg::OUT_WIDTH-1:0] res_den,
  output logic                                zero_den_error
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  state_t state, state_next;

  // operand magnitudes and signs
  func_t            op;
  logic [W-1:0]     an_m, ad_m, bn_m, bd_m;
  logic             an_s, ad_s, bn_s, bd_s;
  logic             same_den;
  // products / raw fraction in sign-magnitude
  logic [PROD_W-1:0] p_m, q_m;
  logic              p_s, q_s;
  logic [MAG_W-1:0]  num_m, den_m;
  logic              num_s, den_s;
  logic              err;
  // euclid
  logic [MAG_W-1:0]  gx, gy;
  logic              odd;
  logic              g_s;
  logic [MAG_W-1:0]  rn_m;
  logic              rn_s;
  // shared multiplier
  logic [W-1:0]      mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  // divider
  div_req_t          dreq;
  div_rsp_t          drsp;
  state_t            after_div;

  rau_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
    mag_of = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  // widen the magnitude first so the sign reaches every output bit
  function automatic logic [OUT_WIDTH-1:0] to_tc(input logic s, input logic [MAG_W-1:0] m);
    logic [MAG_W+OUT_WIDTH-1:0] v;
    v = (MAG_W+OUT_WIDTH)'(m);
    if (s) v = ~v + 1'b1;
    to_tc = v[OUT_WIDTH-1:0];
  endfunction

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    mul_a = an_m;
    mul_b = bd_m;
    case (state)
      ST_MUL1: begin
        mul_a = an_m;
        mul_b = (op == FUNC_MUL) ? bn_m : bd_m;
      end
      ST_MUL2: begin
        mul_a = (op == FUNC_DIV) ? bn_m : ((op == FUNC_MUL) ? bd_m : bn_m);
        mul_b = ad_m;
      end
      ST_MUL3: begin
        mul_a = ad_m;
        mul_b = bd_m;
      end
      default: ;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_MUL1;
      ST_MUL1:      state_next = ST_MUL2;
      ST_MUL2:      state_next = ST_MUL3;
      ST_MUL3:      state_next = ST_SUM;
      ST_SUM:       state_next = ST_GCD_START;
      ST_GCD_START: state_next = (gy == '0) ? ST_RED_NUM : ST_DIV_WAIT;
      ST_GCD_DIV:   state_next = ST_GCD_START;
      ST_RED_NUM:   state_next = (gx == '0) ? ST_OUT : ST_DIV_WAIT;
      ST_RED_DEN:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (drsp.done) state_next = after_div;
      ST_OUT:       if (out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign out_valid = (state == ST_OUT);

  always_comb begin
    dreq.start = 1'b0;
    dreq.dividend = gx;
    dreq.divisor = gy;
    if (state == ST_GCD_START && gy != '0) dreq.start = 1'b1;
    if (state == ST_RED_NUM && gx != '0) begin
      dreq.start = 1'b1;
      dreq.dividend = num_m;
      dreq.divisor = gx;
    end
    if (state == ST_RED_DEN) begin
      dreq.start = 1'b1;
      dreq.dividend = den_m;
      dreq.divisor = gx;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (in_valid) begin
        op <= func_t'(func);
        an_m <= mag_of(a_num); an_s <= a_num[W-1];
        ad_m <= mag_of(a_den); ad_s <= a_den[W-1];
        bn_m <= mag_of(b_num); bn_s <= b_num[W-1];
        bd_m <= mag_of(b_den); bd_s <= b_den[W-1];
        same_den <= (a_den == b_den);
      end
      ST_MUL1: begin
        p_m <= mul_p;
        p_s <= (op == FUNC_MUL) ? (an_s ^ bn_s) : (an_s ^ bd_s);
      end
      ST_MUL2: begin
        q_m <= mul_p;
        q_s <= (op == FUNC_DIV) ? (ad_s ^ bn_s) :
               ((op == FUNC_MUL) ? (ad_s ^ bd_s) : (bn_s ^ ad_s));
      end
      ST_MUL3: begin
        // for add/sub q is bn*ad; den takes ad*bd, or ad alone when the denominators match
        if (op == FUNC_ADD || op == FUNC_SUB) begin
          den_m <= same_den ? MAG_W'(ad_m) : MAG_W'(mul_p);
          den_s <= same_den ? ad_s : (ad_s ^ bd_s);
        end else begin
          den_m <= MAG_W'(q_m);
          den_s <= q_s;
        end
      end
      ST_SUM: begin
        logic [MAG_W-1:0] xm, ym, sm;
        logic xs, ys, ss;
        if (op == FUNC_ADD || op == FUNC_SUB) begin
          xm = same_den ? MAG_W'(an_m) : MAG_W'(p_m);
          xs = same_den ? an_s : p_s;
          ym = same_den ? MAG_W'(bn_m) : MAG_W'(q_m);
          ys = (same_den ? bn_s : q_s) ^ (op == FUNC_SUB);
          if (xs == ys) begin sm = xm + ym; ss = xs; end
          else if (xm >= ym) begin sm = xm - ym; ss = xs; end
          else begin sm = ym - xm; ss = ys; end
        end else begin
          sm = MAG_W'(p_m);
          ss = p_s;
        end
        num_m <= sm;
        num_s <= ss && (sm != '0);
        den_s <= den_s && (den_m != '0);
        err <= (ad_m == '0) || (bd_m == '0) || (den_m == '0);
        gx <= sm;
        gy <= den_m;
        odd <= 1'b0;
      end
      ST_GCD_START: if (gy == '0) g_s <= odd ? den_s : num_s;
      ST_DIV_WAIT: if (drsp.done) begin
        if (after_div == ST_GCD_DIV) begin
          gx <= gy;
          gy <= drsp.rem;
          odd <= ~odd;
        end else if (after_div == ST_RED_DEN) begin
          rn_m <= drsp.quot;
          rn_s <= (num_s ^ g_s) && (drsp.quot != '0);
        end else begin
          res_num <= to_tc(rn_s, rn_m);
          res_den <= to_tc((den_s ^ g_s) && (drsp.quot != '0), drsp.quot);
          zero_den_error <= err;
        end
      end
      ST_RED_NUM: if (gx == '0) begin
        res_num <= to_tc(num_s, num_m);
        res_den <= to_tc(den_s, den_m);
        zero_den_error <= err;
      end
      default: ;
    endcase
    case (state)
      ST_GCD_START: after_div <= ST_GCD_DIV;
      ST_RED_NUM:   after_div <= ST_RED_DEN;
      ST_RED_DEN:   after_div <= ST_OUT;
      default: ;
    endcase
  end

  // only idle takes a request
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("ready while result pending");
  // divider is only started when idle
  assert property (@(posedge clk) disable iff (rst) dreq.start |-> !drsp.busy)
    else $error("divider restarted while busy");
  // result held while stalled
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(res_num) && $stable(res_den)))
    else $error("result changed under stall");
endmodule

[dv/tb.sv]
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 100ps

module tb;
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;
  localparam int OW = OUT_WIDTH;
  localparam int N_RANDOM = 750;
  localparam int QUIET_TAIL = 120;     // last requests sent without idling
  localparam longint CYCLE_LIMIT = 64'd10000000;

  typedef struct {
    logic [1:0] fn;
    logic signed [W-1:0] an, ad, bn, bd;
  } req_t;

  typedef struct packed {
    logic signed [OW-1:0] num;
    logic signed [OW-1:0] den;
    logic err;
  } frac_res_t;

  // directed row: request, plus a hand-typed answer where it is obvious
  typedef struct {
    req_t r;
    bit typed;
    frac_res_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = '0;
  logic signed [W-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OW-1:0] res_num, res_den;
  logic zero_den_error;

  frac_res_t reduced_q[$];
  int mismatches = 0;
  longint cycles = 0;
  bit calm = 0;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rational_arith_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_num(res_num), .res_den(res_den), .zero_den_error(zero_den_error)
  );

  // Exact predictor: signed 80-bit math covers all products and sums.
  function automatic frac_res_t reduce_fraction(req_t r);
    frac_res_t o;
    logic signed [79:0] an, ad, bn, bd, n, d, x, y, t, g;
    bit odd;
    an = 80'(r.an); ad = 80'(r.ad); bn = 80'(r.bn); bd = 80'(r.bd);
    if (r.fn == FUNC_ADD || r.fn == FUNC_SUB) begin
      if (r.ad == r.bd) begin
        n = (r.fn == FUNC_ADD) ? an + bn : an - bn;
        d = ad;
      end else begin
        n = (r.fn == FUNC_ADD) ? an * bd + bn * ad : an * bd - bn * ad;
        d = ad * bd;
      end
    end else if (r.fn == FUNC_MUL) begin
      n = an * bn;
      d = ad * bd;
    end else begin
      n = an * bd;
      d = ad * bn;
    end
    o.err = (ad == 0) || (bd == 0) || (d == 0);
    // Euclid on magnitudes; sign of gcd follows truncated remainder chain
    x = (n < 0) ? -n : n;
    y = (d < 0) ? -d : d;
    odd = 0;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
      odd = !odd;
    end
    g = x;
    if (g != 0 && (odd ? d < 0 : n < 0)) g = -g;
    if (g != 0) begin
      n = n / g;
      d = d / g;
    end
    o.num = n[OW-1:0];
    o.den = d[OW-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [OW-1:0] got, logic [OW-1:0] want);
    $display("MISMATCH @%0t %s got %0d want %0d", $time, what,
             $signed(got), $signed(want));
    mismatches++;
  endtask

  task automatic idle_burst();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) @(negedge clk);
  endtask

  // Present one request at a falling edge; valid held until the accepting
  // edge and dropped only for an idle burst or at the end of the run.
  task automatic send_request(req_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      idle_burst();
    end
    func <= r.fn; a_num <= r.an; a_den <= r.ad; b_num <= r.bn; b_den <= r.bd;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    reduced_q.push_back(reduce_fraction(r));
    @(negedge clk);
  endtask

  function automatic req_t mk(logic [1:0] fn, int an, int ad, int bn, int bd);
    req_t r;
    r.fn = fn; r.an = W'(an); r.ad = W'(ad); r.bn = W'(bn); r.bd = W'(bd);
    return r;
  endfunction

  function automatic logic signed [W-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(0, 20))) - 16'sd10;
      2: return $signed(16'($urandom_range(0, 600))) - 16'sd300;
      default: return 16'($urandom);
    endcase
  endfunction

  // Result side: random stall bursts, none in the tail.
  always @(negedge clk) begin
    if (rst || calm) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frac_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (reduced_q.size() == 0) begin
        $display("MISMATCH @%0t unexpected result", $time);
        mismatches++;
      end else begin
        e = reduced_q.pop_front();
        if (res_num !== e.num) report_mismatch("res_num", res_num, e.num);
        if (res_den !== e.den) report_mismatch("res_den", res_den, e.den);
        if (zero_den_error !== e.err)
          report_mismatch("zero_den_error", OW'(zero_den_error), OW'(e.err));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  row_t rows[$];

  task automatic add_row(req_t r, bit typed, longint n, longint d, bit err);
    row_t w;
    w.r = r; w.typed = typed;
    w.want.num = n[OW-1:0]; w.want.den = d[OW-1:0]; w.want.err = err;
    rows.push_back(w);
  endtask

  initial begin
    req_t r;
    // Directed table: operations, extremes, equal denominators, zero cases.
    add_row(mk(FUNC_ADD, 1, 2, 1, 3), 1, 5, 6, 0);
    add_row(mk(FUNC_SUB, 1, 2, 1, 3), 1, 1, 6, 0);
    add_row(mk(FUNC_MUL, 2, 3, 3, 4), 1, 1, 2, 0);
    add_row(mk(FUNC_DIV, 2, 3, 4, 9), 1, 3, 2, 0);
    add_row(mk(FUNC_ADD, 1, 4, 1, 4), 1, 1, 2, 0);       // equal denominators
    add_row(mk(FUNC_SUB, 3, 4, 3, 4), 0, 0, 0, 0);       // zero numerator
    add_row(mk(FUNC_ADD, 1, 0, 1, 2), 0, 0, 0, 1);       // zero a_den
    add_row(mk(FUNC_MUL, 1, 2, 1, 0), 0, 0, 0, 1);       // zero b_den
    add_row(mk(FUNC_DIV, 5, 3, 0, 7), 1, 1, 0, 1);       // result den zero
    add_row(mk(FUNC_MUL, 0, 0, 0, 0), 1, 0, 0, 1);       // zero over zero
    add_row(mk(FUNC_ADD, 0, 0, 0, 0), 1, 0, 0, 1);
    add_row(mk(FUNC_ADD, 1, -2, 1, 3), 0, 0, 0, 0);      // negative dens
    add_row(mk(FUNC_MUL, -7, 3, 5, -9), 0, 0, 0, 0);
    add_row(mk(FUNC_MUL, -32768, -32768, -32768, -32768), 0, 0, 0, 0);
    add_row(mk(FUNC_ADD, 32767, -32768, 32767, 32767), 0, 0, 0, 0);
    add_row(mk(FUNC_SUB, -32768, 32767, 32767, -32768), 0, 0, 0, 0);
    add_row(mk(FUNC_DIV, 32767, 1, 1, 32767), 0, 0, 0, 0);
    add_row(mk(FUNC_DIV, -32768, 1, -32768, 1), 1, 1, 1, 0);
    add_row(mk(FUNC_ADD, -32768, -32768, -32768, -32768), 0, 0, 0, 0);
    add_row(mk(FUNC_SUB, 0, 5, 0, 7), 0, 0, 0, 0);
    add_row(mk(FUNC_MUL, 21845, 10922, -10923, 21846), 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      // typed answers must agree with the predictor too
      if (rows[i].typed && reduce_fraction(rows[i].r) != rows[i].want) begin
        $display("MISMATCH directed row %0d typed answer disagrees", i);
        mismatches++;
      end
      send_request(rows[i].r);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - QUIET_TAIL) calm = 1;
      r.fn = 2'($urandom);
      r.an = rand_operand(); r.ad = rand_operand();
      r.bn = rand_operand(); r.bd = rand_operand();
      if ($urandom_range(0, 7) == 0) r.bd = r.ad;
      send_request(r);
    end
    in_valid <= 1'b0;

    while (reduced_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && reduced_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

[rational_arith_unit.f]
hw/rtl/rau_pkg.sv
hw/rtl/rau_divider.sv
hw/rtl/rational_arith_unit.sv
dv/tb.sv
